// ----- hdl/dmxdsc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmxdsc_pkg: shared types and constants of the DMX dimmer/strobe controller
// Action and command codes, register indexes, the command carried between
// the front end and the back end, and the quarter-wave sine table builder.
// ----------------------------------------------------------------------------
package dmxdsc_pkg;

  localparam int unsigned LAMP_CHANNELS        = 8;
  localparam int unsigned SINE_QUARTER_ENTRIES = 256;

  localparam int unsigned LANE_BITS  = (LAMP_CHANNELS > 1) ? $clog2(LAMP_CHANNELS) : 1;
  localparam int unsigned QBITS      = $clog2(SINE_QUARTER_ENTRIES);
  localparam int unsigned IDX_BITS   = QBITS + 2;

  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned SINCE_W    = 17;
  localparam int unsigned DARK_W     = 10;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [SLOT_W-1:0] SLOT_LAST     = 10'd512;
  localparam logic [SLOT_W-1:0] FIXTURE_SKIP  = 10'd4;
  localparam logic [31:0]       PHASE_STEP    = 32'd683565;
  localparam logic [31:0]       LANE_OFFSET   = 32'h2000_0000;
  localparam logic [SINCE_W-1:0] SINCE_MAX    = '1;
  localparam logic [BYTE_W-1:0]  LIT_MAX      = '1;
  localparam logic [DARK_W-1:0]  DARK_MAX     = '1;
  localparam logic [BYTE_W-1:0]  STROBE_FULL  = 8'd255;

  localparam logic [63:0] PI_Q40 = 64'h0000_0324_3F6A_8886;
  localparam logic [63:0] ONE_Q30 = 64'h0000_0000_4000_0000;

  // reset values of the configuration registers
  localparam logic [9:0]  RST_START_ADDRESS = 10'd1;
  localparam logic [15:0] RST_DMX_TIMEOUT   = 16'd10000;
  localparam logic [7:0]  RST_FLASH_ON      = 8'd4;
  localparam logic [3:0]  RST_OFF_SCALE     = 4'd2;

  // input action codes
  localparam logic [1:0] ACT_FRAME_START = 2'd0;
  localparam logic [1:0] ACT_SLOT        = 2'd1;
  localparam logic [1:0] ACT_FRAME_END   = 2'd2;
  localparam logic [1:0] ACT_TICK        = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DMX_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_ON      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_SCALE     = 2'd3;

  typedef enum logic [2:0] {
    CMD_FRAME_START,
    CMD_SET_LEVEL,
    CMD_SET_STROBE,
    CMD_FRAME_END,
    CMD_TICK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [LANE_BITS-1:0]  lane;
    logic [BYTE_W-1:0]     value;
  } cmd_t;

  typedef logic [LAMP_CHANNELS-1:0][DUTY_W-1:0] duty_arr_t;

  // Quarter-wave entry k: round((sin((2k+1)*pi/(4Q)) + 1) * 32767.5) in Q30,
  // Taylor series up to x^21. Only evaluated on constants at elaboration;
  // 4Q is a power of two, and each term divides by (2n)(2n+1).
  function automatic logic [DUTY_W-1:0] quarter_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] v;
    x = (((64'(2 * k + 1) * PI_Q40) >> IDX_BITS) + 64'd512) >> 10;
    x2 = (x * x) >> 30;
    sum = x;
    term = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = (term > sum) ? 64'd0 : sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = (term > sum) ? 64'd0 : sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = (term > sum) ? 64'd0 : sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = (term > sum) ? 64'd0 : sum - term;
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd342;
    sum  = (term > sum) ? 64'd0 : sum - term;
    term = ((term * x2) >> 30) / 64'd420;
    sum  = sum + term;
    v = ((sum + ONE_Q30) * 64'd65535 + ONE_Q30) >> 31;
    return (v > 64'd65535) ? 16'hFFFF : v[DUTY_W-1:0];
  endfunction

endpackage

// ----- hdl/dmxdsc_front.sv -----
// ----------------------------------------------------------------------------
// dmxdsc_front: input front end
// Takes input transfers and turns them into back-end commands; slot bytes
// that address nothing in the fixture are consumed without a command.
// ----------------------------------------------------------------------------
module dmxdsc_front (
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      action_i,
  input  logic [dmxdsc_pkg::SLOT_W-1:0]   slot_number_i,
  input  logic [dmxdsc_pkg::BYTE_W-1:0]   slot_value_i,
  input  logic [dmxdsc_pkg::SLOT_W-1:0]   start_address_i,
  input  logic                            q_ready_i,
  output logic                            push_o,
  output dmxdsc_pkg::cmd_t                cmd_o
);

  // offset of the slot from the first dimmer slot, wraps for slots below it
  logic [dmxdsc_pkg::SLOT_W+1:0] offset;
  logic                          slot_ok;
  logic                          hit_level;
  logic                          hit_strobe;
  logic                          relevant;

  assign offset = {2'b00, slot_number_i} - {2'b00, start_address_i}
                - {2'b00, dmxdsc_pkg::FIXTURE_SKIP};
  assign slot_ok    = slot_number_i <= dmxdsc_pkg::SLOT_LAST;
  assign hit_level  = slot_ok && (offset < (dmxdsc_pkg::SLOT_W+2)'(dmxdsc_pkg::LAMP_CHANNELS));
  assign hit_strobe = slot_ok && (offset == (dmxdsc_pkg::SLOT_W+2)'(dmxdsc_pkg::LAMP_CHANNELS));

  always_comb begin
    cmd_o.kind  = dmxdsc_pkg::CMD_TICK;
    cmd_o.lane  = offset[dmxdsc_pkg::LANE_BITS-1:0];
    cmd_o.value = slot_value_i;
    relevant    = 1'b1;
    case (action_i)
      dmxdsc_pkg::ACT_FRAME_START: cmd_o.kind = dmxdsc_pkg::CMD_FRAME_START;
      dmxdsc_pkg::ACT_SLOT: begin
        cmd_o.kind = hit_strobe ? dmxdsc_pkg::CMD_SET_STROBE : dmxdsc_pkg::CMD_SET_LEVEL;
        relevant   = hit_level || hit_strobe;
      end
      dmxdsc_pkg::ACT_FRAME_END: cmd_o.kind = dmxdsc_pkg::CMD_FRAME_END;
      dmxdsc_pkg::ACT_TICK:      cmd_o.kind = dmxdsc_pkg::CMD_TICK;
      default:                   cmd_o.kind = dmxdsc_pkg::CMD_TICK;
    endcase
  end

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i && relevant;

endmodule

// ----- hdl/dmxdsc_queue.sv -----
// ----------------------------------------------------------------------------
// dmxdsc_queue: two-entry command queue
// Decouples the front end from the back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module dmxdsc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dmxdsc_pkg::cmd_t cmd_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output dmxdsc_pkg::cmd_t cmd_o
);

  dmxdsc_pkg::cmd_t entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign ready_o = count_q != 2'd2;
  assign valid_o = count_q != 2'd0;
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- hdl/dmxdsc_back.sv -----
// ----------------------------------------------------------------------------
// dmxdsc_back: command execution
// Holds the frame shadow, committed dimmers, strobe sequencer, frame timeout,
// sine test generator and the result register.
// ----------------------------------------------------------------------------
module dmxdsc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  dmxdsc_pkg::cmd_t                cmd_i,
  output logic                            pop_o,
  input  logic [15:0]                     dmx_timeout_i,
  input  logic [7:0]                      flash_on_i,
  input  logic [3:0]                      off_scale_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output dmxdsc_pkg::duty_arr_t           duty_o,
  output logic                            lamps_lit_o,
  output logic                            test_active_o
);

  localparam int unsigned NL = dmxdsc_pkg::LAMP_CHANNELS;
  localparam int unsigned QB = dmxdsc_pkg::QBITS;
  localparam int unsigned IB = dmxdsc_pkg::IDX_BITS;

  logic [dmxdsc_pkg::BYTE_W-1:0]   shadow_q [NL];
  logic [dmxdsc_pkg::BYTE_W-1:0]   shadow_strobe_q;
  dmxdsc_pkg::duty_arr_t           dimmer_q;
  dmxdsc_pkg::duty_arr_t           drive_q;
  logic [dmxdsc_pkg::BYTE_W-1:0]   strobe_q;
  logic                            lit_q;
  logic [dmxdsc_pkg::BYTE_W-1:0]   lit_el_q;
  logic [dmxdsc_pkg::DARK_W-1:0]   dark_el_q;
  logic [dmxdsc_pkg::SINCE_W-1:0]  since_q;
  logic [31:0]                     phase_q;    // phase after the next tick
  logic                            test_q;
  logic                            out_valid_q;

  logic                            out_free;
  logic                            pop_tick;
  logic [dmxdsc_pkg::SINCE_W-1:0]  since_inc;
  logic [dmxdsc_pkg::BYTE_W-1:0]   lit_inc;
  logic [dmxdsc_pkg::DARK_W-1:0]   dark_inc;
  logic                            test_now;
  logic [11:0]                     dark_time;
  dmxdsc_pkg::duty_arr_t           sine_val;
  dmxdsc_pkg::duty_arr_t           dim_eff;
  logic [dmxdsc_pkg::DUTY_W-1:0]   quarter_rom [dmxdsc_pkg::SINE_QUARTER_ENTRIES];

  // quarter-wave sine table, constants folded at elaboration
  for (genvar k = 0; k < dmxdsc_pkg::SINE_QUARTER_ENTRIES; k++) begin : g_rom
    localparam logic [dmxdsc_pkg::DUTY_W-1:0] ENTRY = dmxdsc_pkg::quarter_entry(k);
    assign quarter_rom[k] = ENTRY;
  end

  // one lookup per lane; odd quadrants mirror the index, upper half inverts
  for (genvar l = 0; l < NL; l++) begin : g_lane
    localparam logic [63:0] OFS = 64'(l) * 64'(dmxdsc_pkg::LANE_OFFSET);
    logic [31:0]                   ph;
    logic [QB-1:0]                 k_idx;
    logic [dmxdsc_pkg::DUTY_W-1:0] ent;
    assign ph       = phase_q + OFS[31:0];
    assign k_idx    = ph[30] ? ~ph[31-2 -: QB] : ph[31-2 -: QB];
    assign ent      = quarter_rom[k_idx];
    assign sine_val[l] = ph[31] ? ~ent : ent;
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign pop_o     = q_valid_i && ((cmd_i.kind != dmxdsc_pkg::CMD_TICK) || out_free);
  assign pop_tick  = pop_o && (cmd_i.kind == dmxdsc_pkg::CMD_TICK);

  assign since_inc = (since_q == dmxdsc_pkg::SINCE_MAX) ? since_q : since_q + 1'b1;
  assign lit_inc   = (lit_el_q == dmxdsc_pkg::LIT_MAX) ? lit_el_q : lit_el_q + 1'b1;
  assign dark_inc  = (dark_el_q == dmxdsc_pkg::DARK_MAX) ? dark_el_q : dark_el_q + 1'b1;
  assign test_now  = since_inc > {1'b0, dmx_timeout_i};
  assign dark_time = 12'(dmxdsc_pkg::STROBE_FULL - strobe_q) * 12'(off_scale_i);
  assign dim_eff   = test_now ? sine_val : dimmer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NL; i++) begin
        shadow_q[i] <= '0;
      end
      shadow_strobe_q <= '0;
      dimmer_q        <= '0;
      drive_q         <= '0;
      strobe_q        <= '0;
      lit_q           <= 1'b0;
      lit_el_q        <= '0;
      dark_el_q       <= dmxdsc_pkg::DARK_MAX;
      since_q         <= '0;
      phase_q         <= dmxdsc_pkg::PHASE_STEP;
      test_q          <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        case (cmd_i.kind)
          dmxdsc_pkg::CMD_FRAME_START: begin
            for (int i = 0; i < NL; i++) begin
              shadow_q[i] <= '0;
            end
            shadow_strobe_q <= '0;
          end
          dmxdsc_pkg::CMD_SET_LEVEL: shadow_q[cmd_i.lane] <= cmd_i.value;
          dmxdsc_pkg::CMD_SET_STROBE: shadow_strobe_q <= cmd_i.value;
          dmxdsc_pkg::CMD_FRAME_END: begin
            for (int i = 0; i < NL; i++) begin
              dimmer_q[i] <= {shadow_q[i], shadow_q[i]};   // byte * 257
            end
            strobe_q <= shadow_strobe_q;
            since_q  <= '0;
          end
          dmxdsc_pkg::CMD_TICK: begin
            out_valid_q <= 1'b1;
            phase_q     <= phase_q + dmxdsc_pkg::PHASE_STEP;
            since_q     <= since_inc;
            lit_el_q    <= lit_inc;
            dark_el_q   <= dark_inc;
            test_q      <= test_now;
            if (test_now) begin
              dimmer_q <= sine_val;
            end
            if (strobe_q == '0) begin
              drive_q <= dim_eff;
            end else if (lit_q) begin
              if (lit_inc > flash_on_i || lit_inc == dmxdsc_pkg::LIT_MAX) begin
                lit_q     <= 1'b0;
                dark_el_q <= '0;
                drive_q   <= '0;
              end
            end else begin
              if (12'(dark_inc) > dark_time || dark_inc == dmxdsc_pkg::DARK_MAX) begin
                lit_q    <= 1'b1;
                lit_el_q <= '0;
                drive_q  <= dim_eff;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign duty_o        = drive_q;
  assign lamps_lit_o   = lit_q;
  assign test_active_o = test_q;

  // a tick only executes when the result register can take it
  a_tick_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_tick |-> (!out_valid_q || out_ready_i))
    else $error("tick executed over an untaken result");

  a_tick_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_tick |=> out_valid_q)
    else $error("tick produced no result");

  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.kind == dmxdsc_pkg::CMD_FRAME_END) |=> (since_q == '0))
    else $error("frame end did not clear the timeout counter");

  a_dark_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(lit_q) |-> (dark_el_q == '0))
    else $error("dark phase started with a stale counter");

  a_strobe_off_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_tick && strobe_q == '0) |=> (drive_q == $past(dim_eff)))
    else $error("duties did not follow dimmers with strobe off");

endmodule

// ----- hdl/dmx_dimmer_strobe_controller_core.sv -----
// ----------------------------------------------------------------------------
// dmx_dimmer_strobe_controller_core: DMX512 dimmer and strobe decoder
// Decodes fixture slots of DMX frames into 8 lamp duties with a strobe
// sequencer and a sine test pattern after a frame timeout.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction | transfer
//  --------+-------------------------------------------+-----------+---------------------
//  in      | in_valid_i/in_ready_o, action_i,          | sink      | valid & ready
//          | slot_number_i, slot_value_i               |           |
//  out     | out_valid_o/out_ready_i, duty_0_o..7_o,   | source    | valid & ready, one
//          | lamps_lit_o, test_active_o                |           | per tick only
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i         | sink      | write when cfg_we_i
//
//  Flow: one item per clock while results are taken; the back end executes one
//    command a cycle unless a tick waits on a held result; a tick's result
//    is registered in the queue, then in the result reg, where it is taken.
//  Reset: asynchronous, active low; registers at their reset values, queue empty.
//  Stalls: a held result blocks only ticks in the back end; the two-entry queue
//    keeps taking items until it is full, then in_ready_o drops.
//  Slot bytes that address nothing in the fixture are taken and dropped.
// ----------------------------------------------------------------------------
module dmx_dimmer_strobe_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [9:0]  slot_number_i,
  input  logic [7:0]  slot_value_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] duty_0_o,
  output logic [15:0] duty_1_o,
  output logic [15:0] duty_2_o,
  output logic [15:0] duty_3_o,
  output logic [15:0] duty_4_o,
  output logic [15:0] duty_5_o,
  output logic [15:0] duty_6_o,
  output logic [15:0] duty_7_o,
  output logic        lamps_lit_o,
  output logic        test_active_o
);

  // configuration registers
  logic [9:0]  start_address_q;
  logic [15:0] dmx_timeout_q;
  logic [7:0]  flash_on_q;
  logic [3:0]  off_scale_q;

  logic                  q_ready;
  logic                  push;
  dmxdsc_pkg::cmd_t      push_cmd;
  logic                  q_valid;
  dmxdsc_pkg::cmd_t      head_cmd;
  logic                  pop;
  dmxdsc_pkg::duty_arr_t duty;

  // writes land immediately; values are masked to register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_address_q <= dmxdsc_pkg::RST_START_ADDRESS;
      dmx_timeout_q   <= dmxdsc_pkg::RST_DMX_TIMEOUT;
      flash_on_q      <= dmxdsc_pkg::RST_FLASH_ON;
      off_scale_q     <= dmxdsc_pkg::RST_OFF_SCALE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dmxdsc_pkg::REG_START_ADDRESS: start_address_q <= cfg_data_i[9:0];
        dmxdsc_pkg::REG_DMX_TIMEOUT:   dmx_timeout_q   <= cfg_data_i;
        dmxdsc_pkg::REG_FLASH_ON:      flash_on_q      <= cfg_data_i[7:0];
        dmxdsc_pkg::REG_OFF_SCALE:     off_scale_q     <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // front end: classify and address-decode each input transfer
  dmxdsc_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .slot_number_i   (slot_number_i),
    .slot_value_i    (slot_value_i),
    .start_address_i (start_address_q),
    .q_ready_i       (q_ready),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  // short command queue between the two halves
  dmxdsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  // back end: shadow, commit, strobe, timeout, sine, result register
  dmxdsc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .dmx_timeout_i (dmx_timeout_q),
    .flash_on_i    (flash_on_q),
    .off_scale_i   (off_scale_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .duty_o        (duty),
    .lamps_lit_o   (lamps_lit_o),
    .test_active_o (test_active_o)
  );

  assign duty_0_o = duty[0];
  assign duty_1_o = duty[1];
  assign duty_2_o = duty[2];
  assign duty_3_o = duty[3];
  assign duty_4_o = duty[4];
  assign duty_5_o = duty[5];
  assign duty_6_o = duty[6];
  assign duty_7_o = duty[7];

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for dmx_dimmer_strobe_controller_core
// Drives DMX frames, slot bytes and millisecond ticks through the input
// channel with random gaps. Each result transfer is checked field by field
// against a local model of the decoder, strobe sequencer and sine test mode.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned LANES        = dmxdsc_pkg::LAMP_CHANNELS;
  localparam int unsigned QUARTER      = dmxdsc_pkg::SINE_QUARTER_ENTRIES;
  localparam logic [31:0] PHASE_INC    = 32'd683565;
  localparam logic [31:0] LANE_STEP    = 32'h2000_0000;
  localparam logic [16:0] AGE_CAP      = 17'h1FFFF;
  localparam logic [7:0]  LIT_CAP      = 8'hFF;
  localparam logic [9:0]  DARK_CAP     = 10'h3FF;
  localparam logic [63:0] PI_FIX       = 64'h0000_0324_3F6A_8886;  // pi in Q40
  localparam logic [63:0] UNIT_FIX     = 64'h0000_0000_4000_0000;  // 1.0 in Q30
  localparam int unsigned DRAIN_CYCLES = 6;   // results pass the queue, then the result register

  // one expected result transfer
  typedef struct packed {
    logic [LANES-1:0][15:0] duty;
    logic                   lit;
    logic                   test;
  } lamp_update_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i      = '0;
  logic [9:0]  slot_number_i = '0;
  logic [7:0]  slot_value_i  = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [15:0] duty_0_o, duty_1_o, duty_2_o, duty_3_o;
  logic [15:0] duty_4_o, duty_5_o, duty_6_o, duty_7_o;
  logic        lamps_lit_o;
  logic        test_active_o;

  dmx_dimmer_strobe_controller_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .slot_number_i (slot_number_i),
    .slot_value_i  (slot_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .duty_0_o      (duty_0_o),
    .duty_1_o      (duty_1_o),
    .duty_2_o      (duty_2_o),
    .duty_3_o      (duty_3_o),
    .duty_4_o      (duty_4_o),
    .duty_5_o      (duty_5_o),
    .duty_6_o      (duty_6_o),
    .duty_7_o      (duty_7_o),
    .lamps_lit_o   (lamps_lit_o),
    .test_active_o (test_active_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model state: configuration, frame shadow, committed levels, strobe
  // counters, frame age and sine phase
  // --------------------------------------------------------------------------
  logic [9:0]  cfg_start;
  logic [15:0] cfg_timeout;
  logic [7:0]  cfg_flash;
  logic [3:0]  cfg_scale;

  logic [7:0]  shadow_lvl [LANES];
  logic [7:0]  shadow_strb;
  logic [15:0] dim_lvl    [LANES];
  logic [7:0]  strobe_byte;
  logic [15:0] drive_lvl  [LANES];
  logic        lit_now;
  logic [7:0]  lit_ms;
  logic [9:0]  dark_ms;
  logic [16:0] frame_age;
  logic [31:0] wave_phase;

  logic [15:0] quarter_wave [QUARTER];

  lamp_update_t lamp_updates_due [$];

  bit calm = 1'b0;   // no gaps, no stalls while set

  int unsigned transfers     = 0;
  int unsigned frames_sent   = 0;
  int unsigned updates_seen  = 0;
  int unsigned sine_updates  = 0;
  int unsigned lit_updates   = 0;
  int unsigned mismatches    = 0;

  // Quarter-wave entry k: sin at the middle of step k, offset and scaled
  // to 16 bits, from a Q30 Taylor series (odd terms up to x^21).
  function automatic logic [15:0] wave_entry(input int unsigned k);
    logic [63:0]  ang;
    logic [63:0]  ang_sq;
    logic [63:0]  acc;
    logic [63:0]  tm;
    logic [63:0]  scaled;
    int unsigned  n;
    ang    = ((64'(2 * k + 1) * PI_FIX) / 64'(4 * QUARTER) + 64'd512) >> 10;
    ang_sq = (ang * ang) >> 30;
    acc    = ang;
    tm     = ang;
    for (n = 1; n <= 10; n++) begin
      tm = ((tm * ang_sq) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
      if (n[0]) acc = (tm > acc) ? 64'd0 : acc - tm;
      else      acc = acc + tm;
    end
    scaled = ((acc + UNIT_FIX) * 64'd65535 + UNIT_FIX) >> 31;
    return (scaled > 64'd65535) ? 16'hFFFF : scaled[15:0];
  endfunction

  // full-wave lookup: odd quadrants mirror the index, upper half inverts
  function automatic logic [15:0] wave_at(input logic [31:0] ph);
    logic [63:0]  idx;
    int unsigned  quad;
    int unsigned  k;
    logic [15:0]  e;
    idx  = (64'(ph) * 64'(4 * QUARTER)) >> 32;
    quad = int'(idx) / QUARTER;
    k    = int'(idx) % QUARTER;
    e    = quad[0] ? quarter_wave[QUARTER - 1 - k] : quarter_wave[k];
    return quad[1] ? 16'hFFFF - e : e;
  endfunction

  task automatic model_reset();
    cfg_start   = 10'd1;
    cfg_timeout = 16'd10000;
    cfg_flash   = 8'd4;
    cfg_scale   = 4'd2;
    for (int i = 0; i < LANES; i++) begin
      shadow_lvl[i] = '0;
      dim_lvl[i]    = '0;
      drive_lvl[i]  = '0;
    end
    shadow_strb = '0;
    strobe_byte = '0;
    lit_now     = 1'b0;
    lit_ms      = '0;
    dark_ms     = DARK_CAP;   // dark counter comes up saturated
    frame_age   = '0;
    wave_phase  = '0;
  endtask

  // Apply one accepted input transfer; ticks queue the update they cause.
  task automatic predict_lamp_update(input logic [1:0] act, input logic [9:0] slot,
                                     input logic [7:0] val);
    lamp_update_t upd;
    int unsigned  dark_span;
    case (act)
      dmxdsc_pkg::ACT_FRAME_START: begin
        for (int i = 0; i < LANES; i++) shadow_lvl[i] = '0;
        shadow_strb = '0;
      end
      dmxdsc_pkg::ACT_SLOT: begin
        // compare at full width so a high start address never aliases
        if (slot <= 10'd512) begin
          for (int i = 0; i < LANES; i++)
            if (32'(slot) == 32'(cfg_start) + 32'd4 + 32'(i)) shadow_lvl[i] = val;
          if (32'(slot) == 32'(cfg_start) + 32'd4 + 32'(LANES)) shadow_strb = val;
        end
      end
      dmxdsc_pkg::ACT_FRAME_END: begin
        for (int i = 0; i < LANES; i++) dim_lvl[i] = 16'(shadow_lvl[i] * 16'd257);
        strobe_byte = shadow_strb;
        frame_age   = '0;
      end
      default: begin
        wave_phase = wave_phase + PHASE_INC;
        if (frame_age != AGE_CAP) frame_age++;
        if (lit_ms != LIT_CAP)    lit_ms++;
        if (dark_ms != DARK_CAP)  dark_ms++;
        upd.test = (32'(frame_age) > 32'(cfg_timeout));
        if (upd.test)
          for (int i = 0; i < LANES; i++) dim_lvl[i] = wave_at(wave_phase + 32'(i) * LANE_STEP);
        if (strobe_byte == 8'd0) begin
          for (int i = 0; i < LANES; i++) drive_lvl[i] = dim_lvl[i];
        end else if (lit_now) begin
          // saturated lit counter counts as elapsed
          if (lit_ms > cfg_flash || lit_ms == LIT_CAP) begin
            lit_now = 1'b0;
            dark_ms = '0;
            for (int i = 0; i < LANES; i++) drive_lvl[i] = '0;
          end
        end else begin
          dark_span = (255 - int'(strobe_byte)) * int'(cfg_scale);
          if (32'(dark_ms) > dark_span || dark_ms == DARK_CAP) begin
            lit_now = 1'b1;
            lit_ms  = '0;
            for (int i = 0; i < LANES; i++) drive_lvl[i] = dim_lvl[i];
          end
        end
        for (int i = 0; i < LANES; i++) upd.duty[i] = drive_lvl[i];
        upd.lit = lit_now;
        lamp_updates_due.push_back(upd);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, driven at the falling edge
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;
  always @(negedge clk_i) begin
    logic        rdy;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) begin
      rdy = 1'b1;
      stall_left = 0;
    end else if (stall_left != 0) begin
      rdy = 1'b0;
      stall_left--;
    end else if (r < 70) begin
      rdy = 1'b1;
    end else if (r < 95) begin
      rdy = 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      rdy = 1'b0;
      stall_left = $urandom_range(15, 50);
    end
    out_ready_i <= rdy;
  end

  // Result checker: every result transfer against the oldest expectation.
  lamp_update_t want;
  lamp_update_t seen;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.duty = {duty_7_o, duty_6_o, duty_5_o, duty_4_o,
                   duty_3_o, duty_2_o, duty_1_o, duty_0_o};
      seen.lit  = lamps_lit_o;
      seen.test = test_active_o;
      if (lamp_updates_due.size() == 0) begin
        $error("result transfer with no tick pending");
        mismatches++;
      end else begin
        want = lamp_updates_due.pop_front();
        updates_seen++;
        if (want.test) sine_updates++;
        if (want.lit)  lit_updates++;
        for (int i = 0; i < LANES; i++)
          if (seen.duty[i] !== want.duty[i]) begin
            $error("duty_%0d: expected %0d, got %0d", i, want.duty[i], seen.duty[i]);
            mismatches++;
          end
        if (seen.lit !== want.lit) begin
          $error("lamps_lit: expected %0b, got %0b", want.lit, seen.lit);
          mismatches++;
        end
        if (seen.test !== want.test) begin
          $error("test_active: expected %0b, got %0b", want.test, seen.test);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side helpers
  // --------------------------------------------------------------------------
  // mostly back-to-back, sometimes short gaps, rarely long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm)   return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // slot byte with the extremes weighted up
  function automatic logic [7:0] pick_level();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // One input transfer. Valid is only lowered when a gap is taken, so a
  // back-to-back item keeps valid high across the edge.
  task automatic send_item(input logic [1:0] act, input logic [9:0] slot,
                           input logic [7:0] val);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    slot_number_i <= slot;
    slot_value_i  <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_lamp_update(act, slot, val);
    transfers++;
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(dmxdsc_pkg::ACT_TICK, 10'($urandom), 8'($urandom));
  endtask

  // A well-formed frame around the fixture window: start code, slots from
  // start+3 to start+13 with some dropped, an occasional ignored slot
  // above 512, then frame end.
  task automatic send_frame(input int unsigned drop_pct, input int unsigned strobe_lo,
                            input int unsigned strobe_hi);
    int unsigned s;
    int unsigned strobe_slot;
    logic [7:0]  v;
    strobe_slot = int'(cfg_start) + 4 + LANES;
    send_item(dmxdsc_pkg::ACT_FRAME_START, 10'($urandom), 8'($urandom));
    send_item(dmxdsc_pkg::ACT_SLOT, 10'd0, 8'($urandom));
    for (s = int'(cfg_start) + 3; s <= strobe_slot + 1; s++) begin
      if (s <= 1023 && $urandom_range(0, 99) >= drop_pct) begin
        v = (s == strobe_slot) ? 8'($urandom_range(strobe_lo, strobe_hi)) : pick_level();
        send_item(dmxdsc_pkg::ACT_SLOT, 10'(s), v);
      end
    end
    if ($urandom_range(0, 3) == 0)
      send_item(dmxdsc_pkg::ACT_SLOT, 10'($urandom_range(513, 1023)), 8'($urandom));
    send_item(dmxdsc_pkg::ACT_FRAME_END, 10'($urandom), 8'($urandom));
    frames_sent++;
  endtask

  // Let the block go idle: nothing expected, then its latency on top.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (lamp_updates_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Register write, only while idle; the model takes the masked value.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      dmxdsc_pkg::REG_START_ADDRESS: cfg_start   = data[9:0];
      dmxdsc_pkg::REG_DMX_TIMEOUT:   cfg_timeout = data;
      dmxdsc_pkg::REG_FLASH_ON:      cfg_flash   = data[7:0];
      default:                       cfg_scale   = data[3:0];
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset defaults, slot range edges, missing slots, commit without frame
  // start, and a short strobe burst with the reset timing.
  task automatic test_directed();
    send_item(dmxdsc_pkg::ACT_TICK, 10'h3FF, 8'hFF);         // all zero after reset
    send_item(dmxdsc_pkg::ACT_FRAME_START, 10'h000, 8'h00);
    send_item(dmxdsc_pkg::ACT_SLOT, 10'd0, 8'h00);           // start code, no fixture slot
    send_item(dmxdsc_pkg::ACT_SLOT, 10'd5, 8'hFF);           // dimmer 0 full
    send_item(dmxdsc_pkg::ACT_SLOT, 10'd9, 8'h01);
    send_item(dmxdsc_pkg::ACT_SLOT, 10'd12, 8'h80);          // dimmer 7
    send_item(dmxdsc_pkg::ACT_SLOT, 10'd13, 8'h00);          // strobe off
    send_item(dmxdsc_pkg::ACT_SLOT, 10'd512, 8'hAA);         // last legal slot
    send_item(dmxdsc_pkg::ACT_SLOT, 10'd513, 8'h55);         // beyond the frame: dropped
    send_item(dmxdsc_pkg::ACT_SLOT, 10'h3FF, 8'h5A);
    send_item(dmxdsc_pkg::ACT_FRAME_END, 10'h000, 8'h00);
    send_ticks(2);
    send_item(dmxdsc_pkg::ACT_SLOT, 10'd6, 8'h7F);           // no frame start before it
    send_item(dmxdsc_pkg::ACT_FRAME_END, 10'h2AA, 8'h55);    // commits the shadow as held
    send_ticks(1);
    send_item(dmxdsc_pkg::ACT_FRAME_START, 10'h155, 8'hAA);  // only the strobe slot arrives,
    send_item(dmxdsc_pkg::ACT_SLOT, 10'd13, 8'hFF);          // dimmers read as zero
    send_item(dmxdsc_pkg::ACT_FRAME_END, 10'h000, 8'h00);
    send_ticks(6);                                           // saturated dark: lit at once
  endtask

  // Start address sweep, including values that can never fully match and
  // data with bits above the register width.
  task automatic test_address_map();
    logic [15:0] addrs [7];
    addrs = '{16'd1, 16'd0, 16'd503, 16'd512, 16'd1023, 16'hFC07,
              16'($urandom_range(2, 500))};
    settle();
    write_reg(dmxdsc_pkg::REG_DMX_TIMEOUT, 16'hFFFF);
    for (int a = 0; a < 7; a++) begin
      settle();
      write_reg(dmxdsc_pkg::REG_START_ADDRESS, addrs[a]);
      repeat (2) begin
        send_frame(20, 0, ($urandom_range(0, 3) == 0) ? 255 : 0);
        send_ticks($urandom_range(2, 5));
      end
    end
  endtask

  // Strobe sequencing over several flash and dark settings.
  task automatic test_strobe();
    logic [7:0] flash_set [4];
    logic [3:0] scale_set [4];
    flash_set = '{8'd0, 8'd3, 8'd1, 8'($urandom_range(0, 10))};
    scale_set = '{4'd0, 4'd1, 4'd2, 4'($urandom_range(0, 3))};
    settle();
    write_reg(dmxdsc_pkg::REG_START_ADDRESS, 16'd1);
    for (int c = 0; c < 4; c++) begin
      settle();
      write_reg(dmxdsc_pkg::REG_FLASH_ON, {8'($urandom), flash_set[c]});   // upper byte masked
      write_reg(dmxdsc_pkg::REG_OFF_SCALE, {12'($urandom), scale_set[c]});
      repeat (2) begin
        case ($urandom_range(0, 3))
          0:       send_frame(10, 0, 0);       // strobe off holds the lit flag
          1:       send_frame(10, 1, 255);
          default: send_frame(10, 200, 255);
        endcase
        send_ticks($urandom_range(10, 30));
      end
    end
  endtask

  // Frame timeout into sine test mode, with and without strobe.
  task automatic test_sine_mode();
    settle();
    write_reg(dmxdsc_pkg::REG_DMX_TIMEOUT, 16'd0);           // every tick is in test mode
    send_frame(30, 0, 0);
    send_ticks(40);
    send_frame(30, 220, 255);
    send_ticks(20);
    for (int c = 0; c < 2; c++) begin
      settle();
      write_reg(dmxdsc_pkg::REG_DMX_TIMEOUT, 16'($urandom_range(1, 30)));
      repeat (2) begin
        send_frame(20, 0, ($urandom_range(0, 1) == 0) ? 0 : 255);
        send_ticks($urandom_range(10, 50));
      end
    end
  endtask

  // Long lit phase that ends only at its counter cap, then a dark span
  // far beyond the run.
  task automatic test_counter_saturation();
    settle();
    calm = 1'b1;
    write_reg(dmxdsc_pkg::REG_DMX_TIMEOUT, 16'hFFFF);
    write_reg(dmxdsc_pkg::REG_FLASH_ON, 16'd255);            // lit ends only at the cap
    write_reg(dmxdsc_pkg::REG_OFF_SCALE, 16'd15);            // dark span beyond the cap
    send_frame(0, 1, 1);
    send_ticks(300);
    settle();
    calm = 1'b0;
  endtask

  // Random settings; mostly well-formed frames and ticks, some noise.
  task automatic test_random_traffic();
    int unsigned goal;
    for (int p = 0; p < 4; p++) begin
      settle();
      case ($urandom_range(0, 4))
        0:       write_reg(dmxdsc_pkg::REG_START_ADDRESS, 16'd512);
        1:       write_reg(dmxdsc_pkg::REG_START_ADDRESS, 16'd1);
        default: write_reg(dmxdsc_pkg::REG_START_ADDRESS, 16'($urandom_range(0, 520)));
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(dmxdsc_pkg::REG_DMX_TIMEOUT, 16'd0);
        1:       write_reg(dmxdsc_pkg::REG_DMX_TIMEOUT, 16'($urandom_range(1, 40)));
        2:       write_reg(dmxdsc_pkg::REG_DMX_TIMEOUT, 16'd10000);
        default: write_reg(dmxdsc_pkg::REG_DMX_TIMEOUT, 16'hFFFF);
      endcase
      write_reg(dmxdsc_pkg::REG_FLASH_ON,
                ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255))
                                            : 16'($urandom_range(0, 6)));
      write_reg(dmxdsc_pkg::REG_OFF_SCALE, 16'($urandom));
      calm = (p == 2);                           // one phase at full rate
      goal = transfers + 50;
      while (transfers < goal) begin
        if ($urandom_range(0, 99) < 80) begin
          send_frame($urandom_range(0, 40), 0, ($urandom_range(0, 1) == 0) ? 0 : 255);
          send_ticks($urandom_range(1, 10));
        end else begin
          send_item(2'($urandom), 10'($urandom), 8'($urandom));
        end
      end
      calm = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < QUARTER; k++) quarter_wave[k] = wave_entry(k);
    model_reset();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_address_map();
    test_strobe();
    test_sine_mode();
    test_counter_saturation();
    test_random_traffic();

    settle();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d input transfers in %0d frames; checked %0d lamp updates",
             transfers, frames_sent, updates_seen);
    $display("  (%0d in sine test mode, %0d with lamps lit)", sine_updates, lit_updates);
    if (mismatches == 0) begin
      $display("dmx_dimmer_strobe_controller_core verification clean");
    end else begin
      $display("dmx_dimmer_strobe_controller_core verification failed");
    end
    $finish;
  end

  // watchdog: well past the slowest legal run
  initial begin
    #10_000_000;
    $display("dmx_dimmer_strobe_controller_core verification failed");
    $finish;
  end

endmodule
